// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ICU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ICU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icu assertion failed");

`endif

// ----- hdl/icu_pkg.sv -----
// ----------------------------------------------------------------------------
// icu_pkg
// Types and codes shared by the instruction cache unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package icu_pkg;

  localparam int BUS_W = 24;

  // operation codes
  localparam logic [2:0] OP_FETCH  = 3'd0;
  localparam logic [2:0] OP_FILL   = 3'd1;
  localparam logic [2:0] OP_CWRITE = 3'd2;
  localparam logic [2:0] OP_CREAD  = 3'd3;
  localparam logic [2:0] OP_FLUSH  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_FILL_REQ = 2'd1;
  localparam logic [1:0] KIND_UNCACHED = 2'd2;

  // request targets
  localparam logic [1:0] TGT_ROM  = 2'd0;
  localparam logic [1:0] TGT_RAM  = 2'd1;
  localparam logic [1:0] TGT_OPEN = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CACHE_BASE = 2'd0;
  localparam logic [1:0] CFG_ROM_MASK   = 2'd1;
  localparam logic [1:0] CFG_RAM_MASK   = 2'd2;

  // bus decode constants
  localparam logic [BUS_W-1:0] ROM_LO_SEL   = 24'hc00000;
  localparam logic [BUS_W-1:0] ROM_LO_BANK  = 24'h3f0000;
  localparam logic [BUS_W-1:0] ROM_LO_OFS   = 24'h007fff;
  localparam logic [BUS_W-1:0] ROM_HI_SEL   = 24'he00000;
  localparam logic [BUS_W-1:0] ROM_HI_MATCH = 24'h400000;
  localparam logic [BUS_W-1:0] RAM_SEL      = 24'hfe0000;
  localparam logic [BUS_W-1:0] RAM_MATCH    = 24'h700000;

  typedef struct packed {
    logic [1:0]       target;
    logic [BUS_W-1:0] phys;
  } dec_t;

endpackage

`default_nettype wire

// ----- hdl/icu_ram.sv -----
// ----------------------------------------------------------------------------
// icu_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module icu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/icu_decode.sv -----
// ----------------------------------------------------------------------------
// icu_decode
// Maps a 24-bit bus address to ROM, RAM or open bus and applies the masks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module icu_decode import icu_pkg::*; (
  input  wire logic [BUS_W-1:0] bus_addr,
  input  wire logic [BUS_W-1:0] rom_mask,
  input  wire logic [BUS_W-1:0] ram_mask,
  output dec_t                  dec
);

  always_comb begin
    if ((bus_addr & ROM_LO_SEL) == '0) begin
      // low ROM banks: 32K pages folded together
      dec.target = TGT_ROM;
      dec.phys   = (((bus_addr & ROM_LO_BANK) >> 1) | (bus_addr & ROM_LO_OFS)) & rom_mask;
    end else if ((bus_addr & ROM_HI_SEL) == ROM_HI_MATCH) begin
      dec.target = TGT_ROM;
      dec.phys   = bus_addr & rom_mask;
    end else if ((bus_addr & RAM_SEL) == RAM_MATCH) begin
      dec.target = TGT_RAM;
      dec.phys   = bus_addr & ram_mask;
    end else begin
      dec.target = TGT_OPEN;
      dec.phys   = '0;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/coprocessor_instruction_cache_unit.sv -----
// ----------------------------------------------------------------------------
// coprocessor_instruction_cache_unit
// Instruction cache with per-line valid bits, line fill sequencing and
// ROM/RAM request decoding.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on in_* (valid/stall) and results leave on out_* through an
//   output register; cfg_* writes a register at any time.
//   After reset the byte store is zeroed by a sweep over all CACHE_BYTES
//   entries, one entry per cycle, with in_stall high; valid bits clear at once.
//   Path from the accepting edge to out_valid:
//     fetch hit / cache read: store read, then output register;
//     final fill byte: store write, store read, then output register;
//     fetch miss: LINE_BYTES requests, one per cycle while out_stall is low.
//   Uncached fetch: one request. Fill bytes (other than the last), cache
//   writes and flushes give no result and are taken back to back.
//   An item that reads the store, or sends requests, keeps in_stall high
//   until its last result is in the output register, so the next item
//   waits; the final fill byte first writes the store, then reads it.
//   When out_stall is high the finished result waits in the output
//   register; a pending read or request then holds and in_stall stays high,
//   while items without results are still taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module coprocessor_instruction_cache_unit import icu_pkg::*; #(
  parameter int CACHE_BYTES = 512,
  parameter int LINE_BYTES  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_operation,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_bank,
  input  wire logic [7:0]  in_byte_in,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_byte_out,
  output logic [1:0]       out_target,
  output logic [23:0]      out_phys_address,
  output logic             out_last,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);

  localparam int OFF_W      = $clog2(CACHE_BYTES);
  localparam int LB_W       = $clog2(LINE_BYTES);
  localparam int LN_W       = OFF_W - LB_W;
  localparam int LINE_COUNT = CACHE_BYTES / LINE_BYTES;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_PEND  = 3'd3;
  localparam logic [2:0] ST_REQ   = 3'd4;

  // configuration
  logic [15:0]      base_r;
  logic [BUS_W-1:0] rom_mask_r, ram_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      rom_mask_r <= 24'h1fffff;
      ram_mask_r <= 24'h01ffff;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CACHE_BASE: base_r     <= cfg_wdata[15:0];
        CFG_ROM_MASK:   rom_mask_r <= cfg_wdata;
        CFG_RAM_MASK:   ram_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state
  logic [2:0]            state_r, state_nxt;
  logic [OFF_W-1:0]      clr_r, clr_nxt;
  logic [LINE_COUNT-1:0] valid_r, valid_nxt;
  logic                  fill_active_r, fill_active_nxt;
  logic [LB_W-1:0]       fill_cnt_r, fill_cnt_nxt;
  logic [OFF_W-1:0]      pending_r, pending_nxt;
  logic [LB_W-1:0]       req_cnt_r, req_cnt_nxt;
  logic                  req_unc_r, req_unc_nxt;
  logic [BUS_W-1:0]      req_bus_r, req_bus_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // output payload
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [1:0]  tgt_r, tgt_nxt;
  logic [23:0] phys_r, phys_nxt;
  logic        last_r, last_nxt;

  // byte store
  logic             ram_en, ram_we;
  logic [OFF_W-1:0] ram_addr;
  logic [7:0]       ram_wdata, ram_rdata;

  icu_ram #(.WIDTH(8), .DEPTH(CACHE_BYTES)) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  logic [BUS_W-1:0] dec_bus;
  dec_t             dec;

  icu_decode u_decode (
    .bus_addr (dec_bus),
    .rom_mask (rom_mask_r),
    .ram_mask (ram_mask_r),
    .dec      (dec)
  );

  logic             in_acc, slot_free, req_last, req_load;
  logic [15:0]      offset, line_sum;
  logic [OFF_W-1:0] ca;
  logic [LN_W-1:0]  fetch_line;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign offset     = in_address - base_r;
  assign fetch_line = offset[OFF_W-1:LB_W];
  assign ca         = in_address[OFF_W-1:0] + base_r[OFF_W-1:0];
  // code address of the line start, low line bits dropped below
  assign line_sum   = base_r + {{(16-OFF_W){1'b0}}, fetch_line, {LB_W{1'b0}}};

  assign dec_bus  = req_unc_r ? req_bus_r : {req_bus_r[BUS_W-1:LB_W], req_cnt_r};
  assign req_last = req_unc_r || (req_cnt_r == LB_W'(LINE_BYTES - 1));
  assign req_load = (state_r == ST_REQ) && slot_free;

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    valid_nxt       = valid_r;
    fill_active_nxt = fill_active_r;
    fill_cnt_nxt    = fill_cnt_r;
    pending_nxt     = pending_r;
    req_cnt_nxt     = req_cnt_r;
    req_unc_nxt     = req_unc_r;
    req_bus_nxt     = req_bus_r;
    out_valid_nxt   = out_valid_r && out_stall;
    kind_nxt        = kind_r;
    byte_nxt        = byte_r;
    tgt_nxt         = tgt_r;
    phys_nxt        = phys_r;
    last_nxt        = last_r;
    ram_en          = 1'b0;
    ram_we          = 1'b0;
    ram_addr        = '0;
    ram_wdata       = '0;

    case (state_r)
      ST_CLEAR: begin
        ram_en  = 1'b1;
        ram_we  = 1'b1;
        ram_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == OFF_W'(CACHE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_operation)
            OP_FETCH: begin
              if (offset[15:OFF_W] != '0) begin
                req_unc_nxt = 1'b1;
                req_bus_nxt = {in_bank, in_address};
                state_nxt   = ST_REQ;
              end else if (valid_r[fetch_line]) begin
                ram_en    = 1'b1;
                ram_addr  = offset[OFF_W-1:0];
                state_nxt = ST_READ;
              end else begin
                // miss: (re)start a line fill
                fill_active_nxt = 1'b1;
                fill_cnt_nxt    = '0;
                pending_nxt     = offset[OFF_W-1:0];
                req_unc_nxt     = 1'b0;
                req_cnt_nxt     = '0;
                req_bus_nxt     = {in_bank, line_sum[15:LB_W], {LB_W{1'b0}}};
                state_nxt       = ST_REQ;
              end
            end
            OP_FILL: begin
              if (fill_active_r) begin
                ram_en       = 1'b1;
                ram_we       = 1'b1;
                ram_addr     = {pending_r[OFF_W-1:LB_W], fill_cnt_r};
                ram_wdata    = in_byte_in;
                fill_cnt_nxt = fill_cnt_r + 1'b1;
                if (fill_cnt_r == LB_W'(LINE_BYTES - 1)) begin
                  valid_nxt[pending_r[OFF_W-1:LB_W]] = 1'b1;
                  fill_active_nxt = 1'b0;
                  fill_cnt_nxt    = '0;
                  state_nxt       = ST_PEND;
                end
              end
            end
            OP_CWRITE: begin
              ram_en    = 1'b1;
              ram_we    = 1'b1;
              ram_addr  = ca;
              ram_wdata = in_byte_in;
              if (ca[LB_W-1:0] == '1) begin
                valid_nxt[ca[OFF_W-1:LB_W]] = 1'b1;
              end
            end
            OP_CREAD: begin
              ram_en    = 1'b1;
              ram_addr  = ca;
              state_nxt = ST_READ;
            end
            OP_FLUSH: begin
              valid_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_PEND: begin
        // line is written; fetch the byte that missed
        ram_en    = 1'b1;
        ram_addr  = pending_r;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_BYTE;
          byte_nxt      = ram_rdata;
          tgt_nxt       = TGT_ROM;
          phys_nxt      = '0;
          last_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_REQ: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = req_unc_r ? KIND_UNCACHED : KIND_FILL_REQ;
          byte_nxt      = '0;
          tgt_nxt       = dec.target;
          phys_nxt      = dec.phys;
          last_nxt      = req_last;
          req_cnt_nxt   = req_cnt_r + 1'b1;
          if (req_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      valid_r       <= '0;
      fill_active_r <= 1'b0;
      fill_cnt_r    <= '0;
      pending_r     <= '0;
      req_cnt_r     <= '0;
      req_unc_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      valid_r       <= valid_nxt;
      fill_active_r <= fill_active_nxt;
      fill_cnt_r    <= fill_cnt_nxt;
      pending_r     <= pending_nxt;
      req_cnt_r     <= req_cnt_nxt;
      req_unc_r     <= req_unc_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_bus_r <= req_bus_nxt;
    kind_r    <= kind_nxt;
    byte_r    <= byte_nxt;
    tgt_r     <= tgt_nxt;
    phys_r    <= phys_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_byte_out     = byte_r;
  assign out_target       = tgt_r;
  assign out_phys_address = phys_r;
  assign out_last         = last_r;

  // checks
  `ICU_ASSERT_NOW(a_fill_req_active, clk, rst_n,
    (state_r == ST_REQ) && !req_unc_r, fill_active_r)
  `ICU_ASSERT_NOW(a_idle_count_zero, clk, rst_n, !fill_active_r, fill_cnt_r == '0)
  `ICU_ASSERT_NEXT(a_last_req_ends, clk, rst_n, req_load && req_last, state_r == ST_IDLE)
  `ICU_ASSERT_NOW(a_clear_quiet, clk, rst_n, state_r == ST_CLEAR, !out_valid_r)

endmodule

`default_nettype wire

// ----- bench/icu_reply_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icu_reply_checker
// Watches the item and result channels of the instruction cache unit. It keeps
// its own copy of the byte store, line valid bits and pending line fill, works
// out the bytes and memory requests each item causes, and compares every
// result, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------

module icu_reply_checker import icu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_bank,
  input  logic [7:0]  in_byte_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_result_kind,
  input  logic [7:0]  out_byte_out,
  input  logic [1:0]  out_target,
  input  logic [23:0] out_phys_address,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output int          mismatch_count,
  output int          replies_due,
  output int          items_taken,
  output int          results_taken
);

  localparam int STORE_BYTES = 512;
  localparam int LINE_LEN    = 16;
  localparam int LINES       = STORE_BYTES / LINE_LEN;
  localparam int PRINT_CAP   = 50;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [1:0]  tgt;
    logic [23:0] phys;
    logic        is_last;
  } cache_reply_t;

  logic [7:0]   line_bytes [STORE_BYTES];
  logic         line_ok [LINES];
  logic         filling;
  logic [4:0]   filled;
  logic [8:0]   miss_offset;
  logic [15:0]  code_base;
  logic [23:0]  rom_window;
  logic [23:0]  ram_window;
  cache_reply_t cache_replies [$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
  endtask

  // Bus decode: low ROM banks fold the bank into A15..., high ROM is linear,
  // banks 70-71 are RAM, everything else is open bus.
  function automatic cache_reply_t bus_request(input logic [1:0] kind, input logic [23:0] a,
                                               input logic is_last);
    cache_reply_t r;
    r.kind    = kind;
    r.data    = '0;
    r.is_last = is_last;
    if ((a & ROM_LO_SEL) == '0) begin
      r.tgt  = TGT_ROM;
      r.phys = (((a & ROM_LO_BANK) >> 1) | (a & ROM_LO_OFS)) & rom_window;
    end else if ((a & ROM_HI_SEL) == ROM_HI_MATCH) begin
      r.tgt  = TGT_ROM;
      r.phys = a & rom_window;
    end else if ((a & RAM_SEL) == RAM_MATCH) begin
      r.tgt  = TGT_RAM;
      r.phys = a & ram_window;
    end else begin
      r.tgt  = TGT_OPEN;
      r.phys = '0;
    end
    return r;
  endfunction

  function automatic cache_reply_t byte_reply(input logic [7:0] b);
    cache_reply_t r;
    r.kind    = KIND_BYTE;
    r.data    = b;
    r.tgt     = TGT_ROM;
    r.phys    = '0;
    r.is_last = 1'b1;
    return r;
  endfunction

  task automatic apply_cache_op(input logic [2:0] op, input logic [15:0] addr,
                                input logic [7:0] bank, input logic [7:0] data);
    logic [15:0] ofs;
    logic [15:0] line_addr;
    logic [8:0]  slot;
    ofs  = addr - code_base;
    slot = 9'(addr + code_base);
    case (op)
      OP_FETCH: begin
        if (ofs < 16'(STORE_BYTES)) begin
          if (line_ok[ofs[8:4]]) begin
            cache_replies.push_back(byte_reply(line_bytes[ofs[8:0]]));
          end else begin
            line_addr = (code_base + {ofs[15:4], 4'h0}) & 16'hfff0;
            for (int n = 0; n < LINE_LEN; n++)
              cache_replies.push_back(bus_request(KIND_FILL_REQ,
                                                  {bank, line_addr[15:4], 4'(n)},
                                                  n == LINE_LEN - 1));
            filling     = 1'b1;
            filled      = '0;
            miss_offset = ofs[8:0];
          end
        end else begin
          cache_replies.push_back(bus_request(KIND_UNCACHED, {bank, addr}, 1'b1));
        end
      end
      OP_FILL: begin
        // stray fill bytes with nothing pending are dropped
        if (filling) begin
          line_bytes[{miss_offset[8:4], filled[3:0]}] = data;
          filled++;
          if (filled == 5'(LINE_LEN)) begin
            line_ok[miss_offset[8:4]] = 1'b1;
            filling = 1'b0;
            filled  = '0;
            cache_replies.push_back(byte_reply(line_bytes[miss_offset]));
          end
        end
      end
      OP_CWRITE: begin
        line_bytes[slot] = data;
        if (slot[3:0] == 4'hf)
          line_ok[slot[8:4]] = 1'b1;
      end
      OP_CREAD: cache_replies.push_back(byte_reply(line_bytes[slot]));
      OP_FLUSH: begin
        for (int i = 0; i < LINES; i++)
          line_ok[i] = 1'b0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cache_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < STORE_BYTES; i++)
        line_bytes[i] = '0;
      for (int i = 0; i < LINES; i++)
        line_ok[i] = 1'b0;
      filling     = 1'b0;
      filled      = '0;
      miss_offset = '0;
      code_base   = 16'h0000;
      rom_window  = 24'h1fffff;
      ram_window  = 24'h01ffff;
      cache_replies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CACHE_BASE: code_base  = cfg_wdata[15:0];
          CFG_ROM_MASK:   rom_window = cfg_wdata;
          CFG_RAM_MASK:   ram_window = cfg_wdata;
          default: ;
        endcase
      end
      // a result always leaves after its item is taken, so pop first
      if (out_valid && !out_stall) begin
        results_taken++;
        if (cache_replies.size() == 0) begin
          report("unrequested result", {30'b0, out_result_kind}, '0);
        end else begin
          want = cache_replies.pop_front();
          if (out_result_kind !== want.kind)
            report("result_kind", 32'(out_result_kind), 32'(want.kind));
          if (out_byte_out !== want.data)
            report("byte_out", 32'(out_byte_out), 32'(want.data));
          if (out_target !== want.tgt)
            report("target", 32'(out_target), 32'(want.tgt));
          if (out_phys_address !== want.phys)
            report("phys_address", 32'(out_phys_address), 32'(want.phys));
          if (out_last !== want.is_last)
            report("last", 32'(out_last), 32'(want.is_last));
        end
      end
      if (in_valid && !in_stall) begin
        items_taken++;
        apply_cache_op(in_operation, in_address, in_bank, in_byte_in);
      end
    end
    replies_due = cache_replies.size();
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the instruction cache unit with directed fetches, line fills, direct
// cache accesses and flushes, then random traffic under several register
// settings and idle mixes; the reply checker does all result comparison.
// ----------------------------------------------------------------------------

module testbench import icu_pkg::*;;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_TICKS = 8;
  localparam int PHASE_ITEMS  = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation = OP_FETCH;
  logic [15:0] in_address = '0;
  logic [7:0]  in_bank = '0;
  logic [7:0]  in_byte_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_byte_out;
  logic [1:0]  out_target;
  logic [23:0] out_phys_address;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_CACHE_BASE;
  logic [23:0] cfg_wdata = '0;

  int          mismatch_count;
  int          replies_due;
  int          items_taken;
  int          results_taken;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  logic [15:0] current_base = 16'h0000;

  always #5 clk = ~clk;

  coprocessor_instruction_cache_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_address       (in_address),
    .in_bank          (in_bank),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_byte_out     (out_byte_out),
    .out_target       (out_target),
    .out_phys_address (out_phys_address),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  icu_reply_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_address       (in_address),
    .in_bank          (in_bank),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_byte_out     (out_byte_out),
    .out_target       (out_target),
    .out_phys_address (out_phys_address),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .replies_due      (replies_due),
    .items_taken      (items_taken),
    .results_taken    (results_taken)
  );

  // Receiver: random stall, or a long hold counted here once requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_stall    <= 1'b1;
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(input logic [2:0] op, input logic [15:0] addr,
                           input logic [7:0] bank, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_address   <= addr;
    in_bank      <= bank;
    in_byte_in   <= data;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering items, wait until every result is in, then let the unit idle
  // before the next phase.
  task automatic let_block_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0)
      @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_registers(input logic [15:0] base, input logic [23:0] rom,
                                 input logic [23:0] ram);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CACHE_BASE;
    cfg_wdata <= {8'h00, base};
    @(posedge clk);
    cfg_index <= CFG_ROM_MASK;
    cfg_wdata <= rom;
    @(posedge clk);
    cfg_index <= CFG_RAM_MASK;
    cfg_wdata <= ram;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    current_base = base;
  endtask

  // Spread banks over low ROM, high ROM, RAM and anything at all.
  function automatic logic [7:0] pick_bank();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(8'h3f, 8'h00));
      1:       return 8'($urandom_range(8'h5f, 8'h40));
      2:       return 8'($urandom_range(8'h71, 8'h70));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] cached_pc();
    return current_base + 16'($urandom_range(511));
  endfunction

  task automatic run_random(input int target);
    int          sent;
    int          pick;
    int          cut;
    logic [15:0] line_rel;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        // fetch in the cached window then fill bytes; sometimes flushed first, cut short or interleaved
        if ($urandom_range(3) == 0) begin
          send_item(OP_FLUSH, 16'($urandom), 8'($urandom), 8'($urandom));
          sent++;
        end
        send_item(OP_FETCH, cached_pc(), pick_bank(), 8'($urandom));
        cut = ($urandom_range(9) == 0) ? $urandom_range(15) : 16;
        for (int i = 0; i < cut; i++) begin
          if ($urandom_range(19) == 0) begin
            case ($urandom_range(3))
              0:       send_item(OP_CREAD, 16'($urandom), pick_bank(), 8'($urandom));
              1:       send_item(OP_CWRITE, 16'($urandom), pick_bank(), 8'($urandom));
              2:       send_item(OP_FLUSH, 16'($urandom), pick_bank(), 8'($urandom));
              default: send_item(OP_FETCH, cached_pc(), pick_bank(), 8'($urandom));
            endcase
            sent++;
          end
          send_item(OP_FILL, 16'($urandom), 8'($urandom), 8'($urandom));
        end
        sent += cut + 1;
      end else if (pick < 55) begin
        send_item(OP_FETCH, cached_pc(), pick_bank(), 8'($urandom));
        sent++;
      end else if (pick < 65) begin
        send_item(OP_FETCH, current_base + 16'(512 + $urandom_range(65023)),
                  pick_bank(), 8'($urandom));
        sent++;
      end else if (pick < 72) begin
        send_item(OP_CREAD, 16'($urandom), 8'($urandom), 8'($urandom));
        sent++;
      end else if (pick < 80) begin
        send_item(OP_CWRITE, 16'($urandom), 8'($urandom), 8'($urandom));
        sent++;
      end else if (pick < 85) begin
        // whole line by direct writes; the last byte marks it valid
        line_rel = 16'($urandom_range(31) * 16) - current_base;
        for (int j = 0; j < 16; j++)
          send_item(OP_CWRITE, line_rel + 16'(j), 8'($urandom), 8'($urandom));
        sent += 16;
      end else if (pick < 89) begin
        send_item(OP_FLUSH, 16'($urandom), 8'($urandom), 8'($urandom));
        sent++;
      end else if (pick < 94) begin
        send_item(OP_FILL, 16'($urandom), 8'($urandom), 8'($urandom));
        sent++;
      end else begin
        send_item(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), 16'($urandom),
                  8'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    send_idle_pct = 10;
    recv_idle_pct = 51;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: miss and fill at the reset base, hits, direct access, decode ends
    send_item(OP_FETCH, 16'h0005, 8'h00, 8'h00);
    for (int i = 0; i < 16; i++)
      send_item(OP_FILL, 16'h0000, 8'h00, 8'(i * 17));
    send_item(OP_FETCH, 16'h000f, 8'h00, 8'h00);
    send_item(OP_CREAD, 16'h0000, 8'h00, 8'h00);
    send_item(OP_CWRITE, 16'h01ff, 8'hff, 8'ha5);
    send_item(OP_FETCH, 16'h01ff, 8'hff, 8'h00);
    send_item(OP_FLUSH, 16'h0000, 8'h00, 8'h00);
    send_item(OP_FETCH, 16'hffff, 8'hff, 8'hff);
    send_item(OP_FETCH, 16'h0200, 8'h70, 8'h00);
    send_item(OP_FILL, 16'h0000, 8'h00, 8'h3c);
    send_item(OP_SPARE_HI, 16'hffff, 8'hff, 8'hff);
    let_block_settle();

    // base at the top of the address space, masks fully open
    write_registers(16'hffff, 24'hffffff, 24'hffffff);
    run_random(PHASE_ITEMS);
    let_block_settle();

    send_idle_pct = 51;
    recv_idle_pct = 10;
    write_registers(16'($urandom), 24'h000000, 24'h000000);
    run_random(PHASE_ITEMS);
    let_block_settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_registers(16'($urandom), 24'($urandom), 24'($urandom));
    // long receiver hold while reads keep coming, so the input backs up
    hold_requests++;
    for (int i = 0; i < 24; i++)
      send_item(OP_CREAD, 16'($urandom), 8'($urandom), 8'($urandom));
    run_random(PHASE_ITEMS);
    let_block_settle();

    $display("Ran %0d items and %0d results through fills, hits, uncached fetches,",
             items_taken, results_taken);
    $display("direct cache access and flushes under four register settings.");
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
